@@ rtl/core/gic_pkg.sv @@
package gic_pkg;

    // Slot counts of the three per-slot tables
    localparam int BUTTON_SLOTS = 16;
    localparam int HAT_SLOTS    = 8;
    localparam int AXIS_SLOTS   = 32;

    localparam int BTN_AW  = (BUTTON_SLOTS > 1) ? $clog2(BUTTON_SLOTS) : 1;
    localparam int HAT_AW  = (HAT_SLOTS > 1) ? $clog2(HAT_SLOTS) : 1;
    localparam int AXIS_AW = (AXIS_SLOTS > 1) ? $clog2(AXIS_SLOTS) : 1;

    // Opcodes
    localparam logic [2:0] OP_BUTTON       = 3'd0;
    localparam logic [2:0] OP_HAT          = 3'd1;
    localparam logic [2:0] OP_AXIS_CLAMPED = 3'd2;
    localparam logic [2:0] OP_AXIS_RAW     = 3'd3;
    localparam logic [2:0] OP_BATTERY      = 3'd4;
    localparam logic [2:0] OP_END_PASS     = 3'd5;

    // Event kinds
    localparam logic [1:0] EV_BUTTON  = 2'd0;
    localparam logic [1:0] EV_HAT     = 2'd1;
    localparam logic [1:0] EV_AXIS    = 2'd2;
    localparam logic [1:0] EV_BATTERY = 2'd3;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE         = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HAT_THRESHOLD    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BATTERY_INTERVAL = 2'd3;

    // Hat direction bits
    localparam logic [3:0] HAT_UP    = 4'd1;
    localparam logic [3:0] HAT_RIGHT = 4'd2;
    localparam logic [3:0] HAT_DOWN  = 4'd4;
    localparam logic [3:0] HAT_LEFT  = 4'd8;

    localparam logic signed [17:0] Q_ONE     = 18'sd65536;
    localparam logic signed [17:0] Q_NEG_ONE = -18'sd65536;

    // Input transaction as presented at the port
    typedef struct packed {
        logic [2:0]         opcode;
        logic [4:0]         slot_index;
        logic signed [17:0] sample_a;
        logic signed [17:0] sample_b;
        logic               read_ok;
        logic [31:0]        time_ms;
    } in_item_t;

    // Item after the front stage: everything the update stage needs
    typedef struct packed {
        logic [2:0]         opcode;
        logic [4:0]         slot_index;
        logic               read_ok;
        logic [31:0]        time_ms;
        logic               a_zero;
        logic               a_pos;
        logic [3:0]         hat_mask;
        logic signed [15:0] axis_val;
        logic [6:0]         batt_lvl;
        logic [1:0]         batt_band;
    } s1_item_t;

    typedef struct packed {
        logic [1:0]         event_kind;
        logic [4:0]         event_index;
        logic signed [15:0] event_value;
    } out_item_t;

    // Pipeline control from the top level to the update stage
    typedef struct packed {
        logic adv;
        logic rd_en;
        logic s1_valid;
    } pipe_ctrl_t;

endpackage

@@ rtl/core/gic_in_if.sv @@
interface gic_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         opcode;
    logic [4:0]         slot_index;
    logic signed [17:0] sample_a;
    logic signed [17:0] sample_b;
    logic               read_ok;
    logic [31:0]        time_ms;

    modport source (
        output valid, opcode, slot_index, sample_a, sample_b, read_ok, time_ms,
        input  ready
    );
    modport sink (
        input  valid, opcode, slot_index, sample_a, sample_b, read_ok, time_ms,
        output ready
    );
endinterface

@@ rtl/core/gic_out_if.sv @@
interface gic_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         event_kind;
    logic [4:0]         event_index;
    logic signed [15:0] event_value;

    modport source (
        output valid, event_kind, event_index, event_value,
        input  ready
    );
    modport sink (
        input  valid, event_kind, event_index, event_value,
        output ready
    );
endinterface

@@ rtl/core/gic_ram.sv @@
module gic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Read-first: a read at the write address returns the old word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

@@ rtl/core/gic_prep.sv @@
module gic_prep (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                accept,
    input  gic_pkg::in_item_t   item,
    input  logic [16:0]         deadzone,
    input  logic [16:0]         hat_threshold,
    output logic                s1_valid,
    output gic_pkg::s1_item_t   s1
);
    import gic_pkg::*;

    logic signed [17:0] a_sat;
    logic signed [17:0] b_sat;
    logic [17:0]        a_mag;
    logic signed [17:0] v;
    logic signed [33:0] v_ext;
    logic signed [33:0] prod;
    logic signed [33:0] prod_adj;
    logic signed [18:0] th_s;
    logic signed [18:0] a_w;
    logic signed [18:0] b_w;
    logic [23:0]        batt_prod;
    logic               s1_valid_reg;
    s1_item_t           s1_next;
    s1_item_t           s1_reg;

    always_comb
    begin
        // Saturate to +-1.0
        if (item.sample_a > Q_ONE)          a_sat = Q_ONE;
        else if (item.sample_a < Q_NEG_ONE) a_sat = Q_NEG_ONE;
        else                                a_sat = item.sample_a;
        if (item.sample_b > Q_ONE)          b_sat = Q_ONE;
        else if (item.sample_b < Q_NEG_ONE) b_sat = Q_NEG_ONE;
        else                                b_sat = item.sample_b;

        a_mag = a_sat[17] ? 18'(-a_sat) : 18'(a_sat);

        // Hat quantiser
        th_s = signed'({2'b00, hat_threshold});
        a_w  = 19'(a_sat);
        b_w  = 19'(b_sat);
        s1_next.hat_mask = 4'd0;
        if (b_w > th_s)       s1_next.hat_mask = s1_next.hat_mask | HAT_DOWN;
        else if (b_w < -th_s) s1_next.hat_mask = s1_next.hat_mask | HAT_UP;
        if (a_w > th_s)       s1_next.hat_mask = s1_next.hat_mask | HAT_RIGHT;
        else if (a_w < -th_s) s1_next.hat_mask = s1_next.hat_mask | HAT_LEFT;

        // Axis: deadzone, then v * 32767 / 65536 truncated toward zero
        if (item.opcode == OP_AXIS_CLAMPED && a_mag <= {1'b0, deadzone})
            v = 18'sd0;
        else
            v = a_sat;
        v_ext    = 34'(v);
        prod     = (v_ext <<< 15) - v_ext;
        prod_adj = prod + (prod[33] ? 34'sd65535 : 34'sd0);
        s1_next.axis_val = 16'(prod_adj >>> 16);

        // Battery level 0..100
        batt_prod = {7'd0, a_sat[16:0]} * 24'd100;
        if (a_sat > 18'sd0) s1_next.batt_lvl = 7'(batt_prod >> 16);
        else                s1_next.batt_lvl = 7'd0;
        if (s1_next.batt_lvl <= 7'd5)       s1_next.batt_band = 2'd0;
        else if (s1_next.batt_lvl <= 7'd20) s1_next.batt_band = 2'd1;
        else if (s1_next.batt_lvl <= 7'd70) s1_next.batt_band = 2'd2;
        else                                s1_next.batt_band = 2'd3;

        s1_next.opcode     = item.opcode;
        s1_next.slot_index = item.slot_index;
        s1_next.read_ok    = item.read_ok;
        s1_next.time_ms    = item.time_ms;
        s1_next.a_zero     = (a_sat == 18'sd0);
        s1_next.a_pos      = (a_sat > 18'sd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1       = s1_reg;
endmodule

@@ rtl/core/gic_update.sv @@
module gic_update (
    input  logic                clk,
    input  logic                rst_n,
    input  gic_pkg::pipe_ctrl_t ctrl,
    input  logic [4:0]          rd_slot,
    input  gic_pkg::s1_item_t   s1,
    input  logic [15:0]         change_threshold,
    input  logic [15:0]         battery_interval_ms,
    output logic                ev_valid,
    output gic_pkg::out_item_t  ev
);
    import gic_pkg::*;

    logic commit;

    // Table ports
    logic                btn_we;
    logic [0:0]          btn_wdata;
    logic [0:0]          btn_q;
    logic                hat_we;
    logic [3:0]          hat_q;
    logic                axis_we;
    logic [15:0]         axis_q;
    logic [BTN_AW-1:0]   btn_addr;
    logic [HAT_AW-1:0]   hat_addr;
    logic [AXIS_AW-1:0]  axis_addr;

    logic [BUTTON_SLOTS-1:0] btn_vld_reg;
    logic [HAT_SLOTS-1:0]    hat_vld_reg;
    logic [AXIS_SLOTS-1:0]   axis_vld_reg;

    // Last committed write, for the item whose read overlapped it
    logic        fwd_en_reg;
    logic [1:0]  fwd_kind_reg;
    logic [4:0]  fwd_slot_reg;
    logic [15:0] fwd_data_reg;
    logic [1:0]  fwd_kind_next;
    logic [15:0] fwd_data_next;

    logic               btn_in_range;
    logic               hat_in_range;
    logic               axis_in_range;
    logic               btn_cur;
    logic [3:0]         hat_cur;
    logic signed [15:0] axis_cur;
    logic signed [16:0] diff;
    logic [16:0]        diff_mag;
    logic [31:0]        elapsed;
    logic               batt_skip;

    logic        hat_seen_reg;
    logic        hat_seen_next;
    logic        axis_seen_reg;
    logic        axis_seen_next;
    logic [31:0] batt_time_reg;
    logic [31:0] batt_time_next;
    logic        batt_timed_reg;
    logic        batt_timed_next;
    logic [6:0]  batt_level_reg;
    logic [6:0]  batt_level_next;
    logic        batt_known_reg;
    logic        batt_known_next;

    logic        emit;
    out_item_t   ev_next;
    logic        ev_valid_reg;
    out_item_t   ev_reg;

    assign commit    = ctrl.s1_valid && ctrl.adv;
    assign btn_addr  = s1.slot_index[BTN_AW-1:0];
    assign hat_addr  = s1.slot_index[HAT_AW-1:0];
    assign axis_addr = s1.slot_index[AXIS_AW-1:0];

    gic_ram #(.WIDTH(1), .DEPTH(BUTTON_SLOTS)) u_btn_ram (
        .clk   (clk),
        .we    (btn_we),
        .waddr (btn_addr),
        .wdata (btn_wdata),
        .re    (ctrl.rd_en),
        .raddr (rd_slot[BTN_AW-1:0]),
        .rdata (btn_q)
    );

    gic_ram #(.WIDTH(4), .DEPTH(HAT_SLOTS)) u_hat_ram (
        .clk   (clk),
        .we    (hat_we),
        .waddr (hat_addr),
        .wdata (s1.hat_mask),
        .re    (ctrl.rd_en),
        .raddr (rd_slot[HAT_AW-1:0]),
        .rdata (hat_q)
    );

    gic_ram #(.WIDTH(16), .DEPTH(AXIS_SLOTS)) u_axis_ram (
        .clk   (clk),
        .we    (axis_we),
        .waddr (axis_addr),
        .wdata (s1.axis_val),
        .re    (ctrl.rd_en),
        .raddr (rd_slot[AXIS_AW-1:0]),
        .rdata (axis_q)
    );

    always_comb
    begin
        btn_in_range  = {1'b0, s1.slot_index} < 6'(BUTTON_SLOTS);
        hat_in_range  = {1'b0, s1.slot_index} < 6'(HAT_SLOTS);
        axis_in_range = {1'b0, s1.slot_index} < 6'(AXIS_SLOTS);

        // Never-written entries read as zero; a write in the read cycle wins
        if (!btn_vld_reg[btn_addr])
            btn_cur = 1'b0;
        else if (fwd_en_reg && fwd_kind_reg == EV_BUTTON && fwd_slot_reg == s1.slot_index)
            btn_cur = fwd_data_reg[0];
        else
            btn_cur = btn_q[0];

        if (!hat_vld_reg[hat_addr])
            hat_cur = 4'd0;
        else if (fwd_en_reg && fwd_kind_reg == EV_HAT && fwd_slot_reg == s1.slot_index)
            hat_cur = fwd_data_reg[3:0];
        else
            hat_cur = hat_q;

        if (!axis_vld_reg[axis_addr])
            axis_cur = 16'sd0;
        else if (fwd_en_reg && fwd_kind_reg == EV_AXIS && fwd_slot_reg == s1.slot_index)
            axis_cur = fwd_data_reg;
        else
            axis_cur = axis_q;

        diff      = 17'(s1.axis_val) - 17'(axis_cur);
        diff_mag  = diff[16] ? 17'(-diff) : 17'(diff);
        elapsed   = s1.time_ms - batt_time_reg;
        batt_skip = batt_timed_reg && (elapsed < {16'd0, battery_interval_ms});
    end

    always_comb
    begin
        btn_we          = 1'b0;
        btn_wdata       = 1'b0;
        hat_we          = 1'b0;
        axis_we         = 1'b0;
        emit            = 1'b0;
        fwd_kind_next   = EV_BUTTON;
        fwd_data_next   = 16'd0;
        hat_seen_next   = hat_seen_reg;
        axis_seen_next  = axis_seen_reg;
        batt_time_next  = batt_time_reg;
        batt_timed_next = batt_timed_reg;
        batt_level_next = batt_level_reg;
        batt_known_next = batt_known_reg;
        ev_next.event_kind  = EV_BUTTON;
        ev_next.event_index = s1.slot_index;
        ev_next.event_value = 16'sd0;

        case (s1.opcode) inside
            OP_BUTTON:
            begin
                if (btn_in_range && ((btn_cur && s1.a_zero) || (!btn_cur && s1.a_pos)))
                begin
                    btn_we              = commit;
                    btn_wdata           = !btn_cur;
                    emit                = 1'b1;
                    fwd_kind_next       = EV_BUTTON;
                    fwd_data_next       = {15'd0, !btn_cur};
                    ev_next.event_value = {15'd0, !btn_cur};
                end
            end
            OP_HAT:
            begin
                if (hat_in_range && s1.read_ok && (!hat_seen_reg || hat_cur != s1.hat_mask))
                begin
                    hat_we              = commit;
                    emit                = 1'b1;
                    fwd_kind_next       = EV_HAT;
                    fwd_data_next       = {12'd0, s1.hat_mask};
                    ev_next.event_kind  = EV_HAT;
                    ev_next.event_value = {12'd0, s1.hat_mask};
                end
            end
            OP_AXIS_CLAMPED, OP_AXIS_RAW:
            begin
                if (axis_in_range && (!axis_seen_reg || diff_mag >= {1'b0, change_threshold}))
                begin
                    axis_we             = commit;
                    emit                = 1'b1;
                    fwd_kind_next       = EV_AXIS;
                    fwd_data_next       = s1.axis_val;
                    ev_next.event_kind  = EV_AXIS;
                    ev_next.event_value = s1.axis_val;
                end
            end
            OP_BATTERY:
            begin
                if (!batt_skip)
                begin
                    batt_time_next  = s1.time_ms;
                    batt_timed_next = 1'b1;
                    if (s1.read_ok && !(batt_known_reg && batt_level_reg == s1.batt_lvl))
                    begin
                        batt_level_next     = s1.batt_lvl;
                        batt_known_next     = 1'b1;
                        emit                = 1'b1;
                        ev_next.event_kind  = EV_BATTERY;
                        ev_next.event_index = 5'd0;
                        ev_next.event_value = {14'd0, s1.batt_band};
                    end
                end
            end
            OP_END_PASS:
            begin
                hat_seen_next  = 1'b1;
                axis_seen_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            btn_vld_reg    <= '0;
            hat_vld_reg    <= '0;
            axis_vld_reg   <= '0;
            fwd_en_reg     <= 1'b0;
            hat_seen_reg   <= 1'b0;
            axis_seen_reg  <= 1'b0;
            batt_time_reg  <= 32'd0;
            batt_timed_reg <= 1'b0;
            batt_level_reg <= 7'd0;
            batt_known_reg <= 1'b0;
            ev_valid_reg   <= 1'b0;
        end
        else
        begin
            if (btn_we)  btn_vld_reg[btn_addr]   <= 1'b1;
            if (hat_we)  hat_vld_reg[hat_addr]   <= 1'b1;
            if (axis_we) axis_vld_reg[axis_addr] <= 1'b1;
            if (ctrl.adv)
            begin
                fwd_en_reg   <= btn_we || hat_we || axis_we;
                ev_valid_reg <= commit && emit;
            end
            if (commit)
            begin
                hat_seen_reg   <= hat_seen_next;
                axis_seen_reg  <= axis_seen_next;
                batt_time_reg  <= batt_time_next;
                batt_timed_reg <= batt_timed_next;
                batt_level_reg <= batt_level_next;
                batt_known_reg <= batt_known_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv)
        begin
            fwd_kind_reg <= fwd_kind_next;
            fwd_slot_reg <= s1.slot_index;
            fwd_data_reg <= fwd_data_next;
        end
        if (commit && emit)
        begin
            ev_reg <= ev_next;
        end
    end

    assign ev_valid = ev_valid_reg;
    assign ev       = ev_reg;
endmodule

@@ rtl/core/gamepad_input_conditioner.sv @@
// An accepted sample passes the front-stage register, then the event output register.
// Throughput: one sample per cycle unless the output stalls; the update stage can read and write
// its slot tables in the same cycle, one memory port for reads and one for writes.
// Reset: rst_n clears all control state; slot tables read as released/centred/zero until
// written, through per-entry valid bits, so no clearing pass is needed.
module gamepad_input_conditioner (
    input  logic                                 clk,
    input  logic                                 rst_n,
    gic_in_if.sink                               samples,
    gic_out_if.source                            events,
    input  logic                                 cfg_wr_en,
    input  logic [gic_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [gic_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
    import gic_pkg::*;

    logic [16:0] deadzone_reg;
    logic [15:0] change_threshold_reg;
    logic [16:0] hat_threshold_reg;
    logic [15:0] battery_interval_reg;

    logic       adv;
    logic       accept;
    logic       s1_valid;
    logic       ev_valid;
    in_item_t   item;
    s1_item_t   s1;
    out_item_t  ev;
    pipe_ctrl_t ctrl;

    // Configuration: the user must write it only while the pipeline is empty; the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadzone_reg         <= 17'd3276;
            change_threshold_reg <= 16'd64;
            hat_threshold_reg    <= 17'd32768;
            battery_interval_reg <= 16'd1000;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_DEADZONE:         deadzone_reg         <= cfg_wdata;
                CFG_CHANGE_THRESHOLD: change_threshold_reg <= cfg_wdata[15:0];
                CFG_HAT_THRESHOLD:    hat_threshold_reg    <= cfg_wdata;
                CFG_BATTERY_INTERVAL: battery_interval_reg <= cfg_wdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    // Advance the whole pipeline whenever the output register is free or
    // being drained; hold everything otherwise.
    assign adv           = !ev_valid || events.ready;
    assign accept        = samples.valid && adv;
    assign samples.ready = adv;

    assign item.opcode     = samples.opcode;
    assign item.slot_index = samples.slot_index;
    assign item.sample_a   = samples.sample_a;
    assign item.sample_b   = samples.sample_b;
    assign item.read_ok    = samples.read_ok;
    assign item.time_ms    = samples.time_ms;

    assign ctrl.adv      = adv;
    assign ctrl.rd_en    = accept;
    assign ctrl.s1_valid = s1_valid;

    // Front stage: saturate, quantise hats, scale axes, compute battery level;
    // table reads are issued in the same cycle.
    gic_prep u_prep (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .accept        (accept),
        .item          (item),
        .deadzone      (deadzone_reg),
        .hat_threshold (hat_threshold_reg),
        .s1_valid      (s1_valid),
        .s1            (s1)
    );

    // Update stage: compare against table contents, write back, drop or
    // register the event.
    gic_update u_update (
        .clk                 (clk),
        .rst_n               (rst_n),
        .ctrl                (ctrl),
        .rd_slot             (samples.slot_index),
        .s1                  (s1),
        .change_threshold    (change_threshold_reg),
        .battery_interval_ms (battery_interval_reg),
        .ev_valid            (ev_valid),
        .ev                  (ev)
    );

    assign events.valid       = ev_valid;
    assign events.event_kind  = ev.event_kind;
    assign events.event_index = ev.event_index;
    assign events.event_value = ev.event_value;
endmodule

@@ verif/gamepad_input_conditioner_tb.sv @@
module gamepad_input_conditioner_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import gic_pkg::*;

    // Opcodes the block has no meaning for; it must drop them silently
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    localparam longint AXIS_FULL     = 32767;
    localparam int     SETTLE_CYCLES = 4;     // covers the front-stage and event registers, with slack
    localparam int     STALL_LIMIT   = 2000;  // cycles with no transaction on either side
    localparam int     PHASE_ITEMS   = 154;   // six random phases plus directed: about 950

    logic clk;
    logic rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    gic_in_if  sample_bus ();
    gic_out_if event_bus ();

    gamepad_input_conditioner uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (sample_bus),
        .events    (event_bus),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the registers and slot tables.
    // Reset is applied once only, so the declared values are the reset state.
    // ------------------------------------------------------------------
    bit [16:0] cfg_deadzone      = 17'd3276;
    bit [15:0] cfg_change_th     = 16'd64;
    bit [16:0] cfg_hat_th        = 17'd32768;
    bit [15:0] cfg_batt_interval = 16'd1000;

    bit        btn_down [BUTTON_SLOTS];
    bit [3:0]  hat_dir  [HAT_SLOTS];
    int        axis_prev [AXIS_SLOTS];
    bit        hats_settled;
    bit        axes_settled;
    bit [31:0] batt_stamp;
    bit        batt_stamp_valid;
    longint    batt_pct;
    bit        batt_pct_valid;

    // Events predicted but not yet seen on the output, oldest first
    out_item_t pending_events[$];

    // Run bookkeeping
    int        src_idle_pct;
    int        snk_idle_pct;
    int        mismatches;
    int        samples_accepted;
    int        events_checked;
    int        settings_applied;
    int        quiet_cycles;
    bit [31:0] battery_clock;

    // Clamp a raw Q16 field into the legal -1.0 .. +1.0 range
    function automatic longint saturate_q16(logic signed [17:0] raw);
        if (raw > Q_ONE)
            return 65536;
        if (raw < Q_NEG_ONE)
            return -65536;
        return longint'(raw);
    endfunction

    // Work out the event one sample causes and advance the slot tables.
    // Returns 1 when an event is due.
    function automatic bit condition_sample(input in_item_t s, output out_item_t ev);
        longint    a;
        longint    b;
        longint    th;
        longint    v;
        longint    lvl;
        int        val;
        int        delta;
        bit [3:0]  mask;
        bit [31:0] elapsed;
        a  = saturate_q16(s.sample_a);
        b  = saturate_q16(s.sample_b);
        ev = '0;
        case (s.opcode)
            OP_BUTTON:
            begin
                if (s.slot_index >= BUTTON_SLOTS)
                    return 1'b0;
                // a pressed button only lets go on an exact zero
                if (btn_down[s.slot_index] && a == 0)
                begin
                    btn_down[s.slot_index] = 1'b0;
                    ev = '{EV_BUTTON, s.slot_index, 16'sd0};
                    return 1'b1;
                end
                if (!btn_down[s.slot_index] && a > 0)
                begin
                    btn_down[s.slot_index] = 1'b1;
                    ev = '{EV_BUTTON, s.slot_index, 16'sd1};
                    return 1'b1;
                end
                return 1'b0;
            end
            OP_HAT:
            begin
                if (s.slot_index >= HAT_SLOTS || !s.read_ok)
                    return 1'b0;
                th   = longint'(cfg_hat_th);
                mask = '0;
                if (b > th)
                    mask |= HAT_DOWN;
                else if (b < -th)
                    mask |= HAT_UP;
                if (a > th)
                    mask |= HAT_RIGHT;
                else if (a < -th)
                    mask |= HAT_LEFT;
                if (hats_settled && hat_dir[s.slot_index] == mask)
                    return 1'b0;
                hat_dir[s.slot_index] = mask;
                ev = '{EV_HAT, s.slot_index, 16'(mask)};
                return 1'b1;
            end
            OP_AXIS_CLAMPED, OP_AXIS_RAW:
            begin
                v = a;
                if (s.opcode == OP_AXIS_CLAMPED && (v < 0 ? -v : v) <= longint'(cfg_deadzone))
                    v = 0;
                val   = int'((v * AXIS_FULL) / 65536);
                delta = val - axis_prev[s.slot_index];
                if (delta < 0)
                    delta = -delta;
                if (axes_settled && delta < int'(cfg_change_th))
                    return 1'b0;
                axis_prev[s.slot_index] = val;
                ev = '{EV_AXIS, s.slot_index, 16'(val)};
                return 1'b1;
            end
            OP_BATTERY:
            begin
                // the interval gate and timestamp apply even to failed reads
                elapsed = s.time_ms - batt_stamp;
                if (batt_stamp_valid && elapsed < 32'(cfg_batt_interval))
                    return 1'b0;
                batt_stamp       = s.time_ms;
                batt_stamp_valid = 1'b1;
                if (!s.read_ok)
                    return 1'b0;
                lvl = (a * 100) / 65536;
                if (lvl < 0)
                    lvl = 0;
                if (lvl > 100)
                    lvl = 100;
                if (batt_pct_valid && lvl == batt_pct)
                    return 1'b0;
                batt_pct       = lvl;
                batt_pct_valid = 1'b1;
                ev.event_kind  = EV_BATTERY;
                ev.event_index = '0;
                ev.event_value = (lvl <= 5)  ? 16'sd0 :
                                 (lvl <= 20) ? 16'sd1 :
                                 (lvl <= 70) ? 16'sd2 : 16'sd3;
                return 1'b1;
            end
            OP_END_PASS:
            begin
                hats_settled = 1'b1;
                axes_settled = 1'b1;
                return 1'b0;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic in_item_t sample_of(logic [2:0] op, int slot, longint a, longint b,
                                           bit ok, logic [31:0] t);
        in_item_t s;
        s.opcode     = op;
        s.slot_index = 5'(slot);
        s.sample_a   = 18'(a);
        s.sample_b   = 18'(b);
        s.read_ok    = ok;
        s.time_ms    = t;
        return s;
    endfunction

    // Q16 level drawn around the zero, the rails, a threshold, or anywhere in 18 bits
    function automatic logic signed [17:0] pick_level(longint th);
        longint v;
        case ($urandom_range(7))
            0: v = 0;
            1: v = 65536;
            2: v = -65536;
            3: v = th + longint'($urandom_range(2)) - 1;
            4: v = -th - longint'($urandom_range(2)) + 1;
            5: return 18'($urandom());
            default: v = longint'($urandom_range(131072)) - 65536;
        endcase
        return 18'(v);
    endfunction

    // One random sample, shaped so that buttons toggle, hats and axes move
    // across their thresholds and battery reads straddle the interval.
    function automatic in_item_t draw_sample();
        in_item_t s;
        longint   base;
        int       span;
        s.opcode     = OP_END_PASS;
        s.slot_index = 5'($urandom());
        s.sample_a   = pick_level(longint'(cfg_hat_th));
        s.sample_b   = pick_level(longint'(cfg_hat_th));
        s.read_ok    = ($urandom_range(99) >= 15);
        s.time_ms    = $urandom();
        case ($urandom_range(19))
            0, 1, 2, 3:
            begin
                s.opcode = OP_BUTTON;
                if ($urandom_range(9) != 0)
                    s.slot_index = 5'($urandom_range(BUTTON_SLOTS - 1));
                if ($urandom_range(2) != 0)
                    s.sample_a = ($urandom_range(1) != 0) ? 18'sd0
                                                           : 18'($urandom_range(1, 65536));
            end
            4, 5, 6, 7:
            begin
                s.opcode = OP_HAT;
                if ($urandom_range(9) != 0)
                    s.slot_index = 5'($urandom_range(HAT_SLOTS - 1));
            end
            8, 9, 10, 11, 12, 13:
            begin
                s.opcode = ($urandom_range(1) != 0) ? OP_AXIS_CLAMPED : OP_AXIS_RAW;
                if ($urandom_range(1) != 0)
                begin
                    // land near the last value so small moves meet the change threshold
                    span = int'(cfg_change_th) * 4 + 4;
                    if (span > 4000)
                        span = 4000;
                    base = (longint'(axis_prev[s.slot_index]) * 65536) / AXIS_FULL
                           + longint'($urandom_range(2 * span)) - span;
                    s.sample_a = 18'(base);
                end
                else
                    s.sample_a = pick_level(longint'(cfg_deadzone));
            end
            14, 15, 16, 17:
            begin
                s.opcode = OP_BATTERY;
                if ($urandom_range(15) == 0)
                    battery_clock = $urandom();
                else
                    battery_clock += $urandom_range(2 * cfg_batt_interval + 2);
                s.time_ms = battery_clock;
                if ($urandom_range(4) != 0)
                    s.sample_a = 18'($urandom_range(66000));
            end
            18:
                s.opcode = OP_END_PASS;
            default:
                s.opcode = ($urandom_range(1) != 0) ? OP_SPARE_LO : OP_SPARE_HI;
        endcase
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Clock and receiver side
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Drop ready at random to stall the output; the rate follows the phase
    always @(posedge clk)
        event_bus.ready <= ($urandom_range(99) >= snk_idle_pct);

    // Compare every event transaction with the oldest prediction
    always @(posedge clk)
    begin : event_checker
        out_item_t want;
        out_item_t got;
        if (rst_n && event_bus.valid && event_bus.ready)
        begin
            got = {event_bus.event_kind, event_bus.event_index, event_bus.event_value};
            if (pending_events.size() == 0)
            begin
                $display("%0t: expected no event, got kind %0d index %0d value %0d",
                         $time, got.event_kind, got.event_index, got.event_value);
                mismatches++;
            end
            else
            begin
                want = pending_events.pop_front();
                events_checked++;
                if (got !== want)
                begin
                    $display({"%0t: event mismatch: expected kind %0d index %0d value %0d,",
                              " got kind %0d index %0d value %0d"},
                             $time, want.event_kind, want.event_index, want.event_value,
                             got.event_kind, got.event_index, got.event_value);
                    mismatches++;
                end
            end
        end
    end

    // Abort when neither side has completed a transaction for too long
    always @(posedge clk)
    begin
        if ((sample_bus.valid && sample_bus.ready) || (event_bus.valid && event_bus.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles, %0d events outstanding",
                     $time, STALL_LIMIT, pending_events.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one sample, hold it until accepted, then predict its event.
    // Valid is left high afterwards: the next call either replaces the
    // payload or drops valid in the same step, so nothing is sent twice.
    task automatic send_sample(input in_item_t s);
        out_item_t ev;
        while ($urandom_range(99) < src_idle_pct)
        begin
            sample_bus.valid <= 1'b0;
            @(posedge clk);
        end
        sample_bus.valid      <= 1'b1;
        sample_bus.opcode     <= s.opcode;
        sample_bus.slot_index <= s.slot_index;
        sample_bus.sample_a   <= s.sample_a;
        sample_bus.sample_b   <= s.sample_b;
        sample_bus.read_ok    <= s.read_ok;
        sample_bus.time_ms    <= s.time_ms;
        @(posedge clk);
        while (!sample_bus.ready)
            @(posedge clk);
        samples_accepted++;
        if (condition_sample(s, ev))
            pending_events.push_back(ev);
    endtask

    // Stop sending, wait for every predicted event, then let the pipeline
    // empty of samples that cause no event.
    task automatic wait_until_drained();
        sample_bus.valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Hold the write enable across back-to-back writes; the caller drops it
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        case (idx)
            CFG_DEADZONE:         cfg_deadzone      = data;
            CFG_CHANGE_THRESHOLD: cfg_change_th     = data[15:0];
            CFG_HAT_THRESHOLD:    cfg_hat_th        = data;
            CFG_BATTERY_INTERVAL: cfg_batt_interval = data[15:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(int unsigned dz, int unsigned ct, int unsigned ht,
                                  int unsigned iv);
        wait_until_drained();
        write_register(CFG_DEADZONE, CFG_DATA_W'(dz));
        write_register(CFG_CHANGE_THRESHOLD, CFG_DATA_W'(ct));
        write_register(CFG_HAT_THRESHOLD, CFG_DATA_W'(ht));
        write_register(CFG_BATTERY_INTERVAL, CFG_DATA_W'(iv));
        cfg_wr_en <= 1'b0;
        settings_applied++;
    endtask

    task automatic run_random_samples(int count);
        in_item_t s;
        repeat (count)
        begin
            s = draw_sample();
            send_sample(s);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked samples under the reset settings: start-up behaviour
    // before the first end of pass, saturation, deadzone edges, slot
    // limits, failed reads, battery rate limit and tick wrap-around.
    task automatic test_directed_cases();
        // press, non-release on a negative value, release on exact zero
        send_sample(sample_of(OP_BUTTON, 0, 1, 0, 1'b1, 0));
        send_sample(sample_of(OP_BUTTON, 0, -1, 0, 1'b1, 0));
        send_sample(sample_of(OP_BUTTON, 0, 0, 0, 1'b1, 0));
        // negative on a released button does nothing; an over-range value presses
        send_sample(sample_of(OP_BUTTON, 15, -65536, 0, 1'b1, 0));
        send_sample(sample_of(OP_BUTTON, 15, 131071, 0, 1'b1, 0));
        send_sample(sample_of(OP_BUTTON, 16, 1, 0, 1'b1, 0));
        // hat on the threshold does not count; start-up repeats the same mask
        send_sample(sample_of(OP_HAT, 0, 32768, -32769, 1'b1, 0));
        send_sample(sample_of(OP_HAT, 0, 32768, -32769, 1'b1, 0));
        send_sample(sample_of(OP_HAT, 7, -131072, 65536, 1'b1, 0));
        send_sample(sample_of(OP_HAT, 3, 65536, 65536, 1'b0, 0));
        send_sample(sample_of(OP_HAT, 8, 65536, 0, 1'b1, 0));
        // deadzone edges, raw axis skipping the deadzone, saturated rails
        send_sample(sample_of(OP_AXIS_CLAMPED, 31, 3276, 0, 1'b1, 0));
        send_sample(sample_of(OP_AXIS_CLAMPED, 0, -3277, 0, 1'b1, 0));
        send_sample(sample_of(OP_AXIS_RAW, 1, 3276, 0, 1'b1, 0));
        send_sample(sample_of(OP_AXIS_RAW, 2, 131071, 0, 1'b1, 0));
        // battery: first read, inside the interval, failed read, below zero
        send_sample(sample_of(OP_BATTERY, 0, 65536, 0, 1'b1, 32'd0));
        send_sample(sample_of(OP_BATTERY, 0, 0, 0, 1'b1, 32'd999));
        send_sample(sample_of(OP_BATTERY, 0, 0, 0, 1'b0, 32'd1000));
        send_sample(sample_of(OP_BATTERY, 0, -5, 0, 1'b1, 32'd2000));
        // tick counter wrapping between two accepted reads
        send_sample(sample_of(OP_BATTERY, 0, 13107, 0, 1'b1, 32'hFFFF_FF00));
        send_sample(sample_of(OP_BATTERY, 0, 45875, 0, 1'b1, 32'h0000_0300));
        // end of pass: small axis moves and repeated hat masks now stay quiet
        send_sample(sample_of(OP_END_PASS, 0, 0, 0, 1'b1, 0));
        send_sample(sample_of(OP_AXIS_RAW, 1, 3336, 0, 1'b1, 0));
        send_sample(sample_of(OP_HAT, 0, 32768, -32769, 1'b1, 0));
        send_sample(sample_of(OP_SPARE_LO, 0, 65536, 65536, 1'b1, 0));
        send_sample(sample_of(OP_SPARE_HI, 31, -65536, -65536, 1'b0, 32'hFFFF_FFFF));
    endtask

    // Every threshold at zero: all moves emit, every hat reading off centre is a direction
    task automatic test_low_thresholds();
        apply_settings(0, 0, 0, 0);
        run_random_samples(PHASE_ITEMS);
    endtask

    // Every threshold at its top: axes go quiet after start-up, hats centre
    task automatic test_high_thresholds();
        apply_settings(65536, 65535, 65536, 65535);
        run_random_samples(PHASE_ITEMS);
    endtask

    task automatic test_typical_settings();
        apply_settings(8000, 300, 40000, 250);
        run_random_samples(PHASE_ITEMS);
    endtask

    task automatic test_random_settings(int rounds);
        repeat (rounds)
        begin
            apply_settings($urandom_range(12000), $urandom_range(2000),
                           $urandom_range(65536), $urandom_range(3000));
            run_random_samples(PHASE_ITEMS);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n                 = 1'b0;
        cfg_wr_en             = 1'b0;
        cfg_index             = '0;
        cfg_wdata             = '0;
        sample_bus.valid      = 1'b0;
        sample_bus.opcode     = OP_BUTTON;
        sample_bus.slot_index = '0;
        sample_bus.sample_a   = '0;
        sample_bus.sample_b   = '0;
        sample_bus.read_ok    = 1'b0;
        sample_bus.time_ms    = '0;
        event_bus.ready       = 1'b0;
        mismatches            = 0;
        samples_accepted      = 0;
        events_checked        = 0;
        settings_applied      = 0;
        quiet_cycles          = 0;
        battery_clock         = '0;

        // light sender gaps, heavy output stalls
        src_idle_pct = 12;
        snk_idle_pct = 49;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_low_thresholds();
        test_high_thresholds();

        // swap: the sender is now the slow side
        src_idle_pct = 49;
        snk_idle_pct = 12;
        test_typical_settings();
        test_random_settings(1);

        // full rate on both sides
        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random_settings(2);

        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d sample transactions and %0d event transactions",
                 samples_accepted, events_checked);
        $display("over reset values plus %0d register settings, threshold extremes included",
                 settings_applied);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
